// ===== rtl/ckm_pkg.sv =====
// Package for the canonical k-mer seed index: table sizing, field widths,
// status codes, table entry layout and control structs. No dependencies.
package ckm_pkg;

    // Table depth; home slot is IDX_W bits taken from the hash, so keep it a power of two.
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;

    localparam int KEY_W    = 62;
    localparam int POS_W    = 32;
    localparam int K_W      = 5;
    localparam int CODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int OFF_W    = 34;
    localparam int SUM_W    = 36;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 136;

    // Hash: bits [32 +: IDX_W] of key * HASH_MULT, built from three half-width products.
    localparam int HASH_W = 32 + IDX_W;
    localparam int HALF_W = (HASH_W + 1) / 2;
    localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

    localparam logic [K_W-1:0] K_RESET = 5'd31;
    localparam logic [K_W-1:0] K_MIN   = 5'd2;

    localparam logic [STATUS_W-1:0] ST_NO_WINDOW = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PALINDROME = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MADE_AMBIG = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_AMBIG     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd7;

    localparam logic REQ_INDEX = 1'b0;

    typedef struct packed {
        logic              used;
        logic              ambiguous;
        logic              reverse;
        logic [POS_W-1:0]  node_length;
        logic [POS_W-1:0]  start;
        logic [POS_W-1:0]  node;
        logic [KEY_W-1:0]  key;
    } seed_entry_t;

    localparam int ENTRY_W = $bits(seed_entry_t);

    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_LL,
        TERM_LH,
        TERM_HL
    } hash_term_t;

    typedef struct packed {
        logic       clear;
        hash_term_t term;
    } hash_ctl_t;

    typedef struct packed {
        logic              en;
        logic              first;
        logic [CODE_W-1:0] code;
    } win_ctl_t;

endpackage

// ===== rtl/canonical_kmer_seed_index.sv =====
// Canonical k-mer seed index: top level with the probe sequencer and seed table.
// Depends on ckm_pkg, ckm_ram, ckm_window, ckm_hash.
//
// Input stream (s_*): one DNA base per transaction; s_tuser selects index (0)
// or query (1). Output stream (m_*): exactly one result per input transaction.
// cfg_we/cfg_wdata set k; write only while no transaction is in flight.
// One item is in work at a time; s_tready is high only when the block is idle.
// Path from input transaction to m_tvalid:
//   no full window or index palindrome: S_EVAL, then S_OUT
//   table lookup: S_EVAL, S_MUL0..S_MUL2 (hash over the shared multiplier, three
//                 products), S_HOME, then per probe slot S_PROBE (RAM read) and
//                 S_CHECK (compare), plus S_POS and S_OFF on a query hit.
// After the output transaction the block returns to S_IDLE to take the next input.
// After reset the seed table is swept clear, one slot per cycle, through all
// TABLE_ENTRIES (4096) slots; s_tready stays low meanwhile.
// A result is held in the output register while m_tready is low; no new
// input is taken until it has been delivered.
module canonical_kmer_seed_index (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ckm_pkg::K_W-1:0]            cfg_wdata,  // kmer_length
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // base_code[2:0], first_of_sequence[3], node_id[35:4], node_length[67:36]
    input  logic [ckm_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,    // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status[2:0], canonical_kmer[64:3], hit_node[96:65], hit_orient[97],
    // hit_offset[131:98], zero pad
    output logic [ckm_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int IW = ckm_pkg::IDX_W;
    localparam int CW = ckm_pkg::CNT_W;
    localparam logic [CW-1:0] N_ENT = CW'(ckm_pkg::TABLE_ENTRIES);
    localparam logic signed [ckm_pkg::SUM_W-1:0] OFF_HI = 36'sd8589934591;
    localparam logic signed [ckm_pkg::SUM_W-1:0] OFF_LO = -36'sd8589934592;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EVAL, S_MUL0, S_MUL1, S_MUL2, S_HOME,
        S_PROBE, S_CHECK, S_POS, S_OFF, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0]  clr_idx_reg, clr_idx_next, slot_reg, slot_next, hash_slot;
    logic [CW-1:0]  key_count_reg, key_count_next, probe_cnt_reg, probe_cnt_next, cnt_inc;
    logic [ckm_pkg::K_W-1:0] kmer_length_reg, kmer_length_next, k_eff, run;
    logic req_reg, req_next, gt_reg, gt_next, orient_reg, orient_next;
    logic [ckm_pkg::CODE_W-1:0] code_reg, code_next;
    logic [ckm_pkg::POS_W-1:0] node_reg, node_next, nlen_reg, nlen_next;
    logic [ckm_pkg::POS_W-1:0] start_reg, start_next, pos;
    logic [ckm_pkg::KEY_W-1:0] canon_reg, canon_next, fwd, rev;
    ckm_pkg::seed_entry_t ent_reg, ent_next, rd_ent, wr_ent;
    logic signed [ckm_pkg::SUM_W-1:0] sum_reg, sum_next, off;
    logic [ckm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ckm_pkg::KEY_W-1:0] out_canon_reg, out_canon_next;
    logic [ckm_pkg::POS_W-1:0] hit_node_reg, hit_node_next;
    logic hit_orient_reg, hit_orient_next;
    logic [ckm_pkg::OFF_W-1:0] hit_off_reg, hit_off_next;
    logic ram_we, in_acc, hit, is_free;
    logic [IW-1:0] ram_waddr;
    logic [ckm_pkg::ENTRY_W-1:0] ram_rdata;
    ckm_pkg::hash_ctl_t hash_ctl;
    ckm_pkg::win_ctl_t  win_ctl;

    assign k_eff    = (kmer_length_reg < ckm_pkg::K_MIN) ? ckm_pkg::K_MIN : kmer_length_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tdata  = {4'b0, hit_off_reg, hit_orient_reg, hit_node_reg, out_canon_reg,
                       status_reg};

    assign win_ctl.en    = in_acc;
    assign win_ctl.first = s_tdata[3];
    assign win_ctl.code  = s_tdata[2:0];

    ckm_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (win_ctl),
        .k       (k_eff),
        .fwd     (fwd),
        .rev     (rev),
        .run     (run),
        .pos     (pos)
    );

    ckm_hash u_hash (
        .aclk (aclk),
        .ctl  (hash_ctl),
        .key  (canon_reg),
        .slot (hash_slot)
    );

    ckm_ram #(
        .WIDTH (ckm_pkg::ENTRY_W),
        .DEPTH (ckm_pkg::TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_ent),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign rd_ent  = ram_rdata;
    assign hit     = rd_ent.used && (rd_ent.key == canon_reg);
    assign is_free = !rd_ent.used;
    assign cnt_inc = probe_cnt_reg + CW'(1);
    assign off     = sum_reg - $signed({4'b0, start_reg});

    always_comb begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        key_count_next   = key_count_reg;
        kmer_length_next = cfg_we ? cfg_wdata : kmer_length_reg;
        req_next         = req_reg;
        code_next        = code_reg;
        node_next        = node_reg;
        nlen_next        = nlen_reg;
        gt_next          = gt_reg;
        canon_next       = canon_reg;
        start_next       = start_reg;
        slot_next        = slot_reg;
        probe_cnt_next   = probe_cnt_reg;
        ent_next         = ent_reg;
        orient_next      = orient_reg;
        sum_next         = sum_reg;
        status_next      = status_reg;
        out_canon_next   = out_canon_reg;
        hit_node_next    = hit_node_reg;
        hit_orient_next  = hit_orient_reg;
        hit_off_next     = hit_off_reg;
        hash_ctl.clear   = 1'b0;
        hash_ctl.term    = ckm_pkg::TERM_NONE;
        ram_we           = 1'b0;
        ram_waddr        = slot_reg;
        wr_ent           = '0;

        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                clr_idx_next = clr_idx_reg + IW'(1);
                if (&clr_idx_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    req_next   = s_tuser;
                    code_next  = s_tdata[2:0];
                    node_next  = s_tdata[35:4];
                    nlen_next  = s_tdata[67:36];
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                hit_node_next   = '0;
                hit_orient_next = 1'b0;
                hit_off_next    = '0;
                canon_next      = (fwd < rev) ? fwd : rev;
                gt_next         = (fwd > rev);
                start_next      = pos + ckm_pkg::POS_W'(1) - {27'b0, k_eff};
                if (code_reg > ckm_pkg::CODE_W'(3) || run < k_eff) begin
                    status_next    = ckm_pkg::ST_NO_WINDOW;
                    out_canon_next = '0;
                    state_next     = S_OUT;
                end else begin
                    out_canon_next = (fwd < rev) ? fwd : rev;
                    if (req_reg == ckm_pkg::REQ_INDEX && fwd == rev) begin
                        status_next = ckm_pkg::ST_PALINDROME;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_MUL0;
                    end
                end
            end
            S_MUL0: begin
                hash_ctl.clear = 1'b1;
                hash_ctl.term  = ckm_pkg::TERM_LL;
                state_next     = S_MUL1;
            end
            S_MUL1: begin
                hash_ctl.term = ckm_pkg::TERM_LH;
                state_next    = S_MUL2;
            end
            S_MUL2: begin
                hash_ctl.term = ckm_pkg::TERM_HL;
                state_next    = S_HOME;
            end
            S_HOME: begin
                slot_next      = hash_slot;
                probe_cnt_next = '0;
                state_next     = S_PROBE;
            end
            S_PROBE: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (!hit && !is_free && cnt_inc != N_ENT) begin
                    probe_cnt_next = cnt_inc;
                    slot_next      = slot_reg + IW'(1);
                    state_next     = S_PROBE;
                end else if (req_reg == ckm_pkg::REQ_INDEX) begin
                    state_next = S_OUT;
                    if (hit) begin
                        wr_ent           = rd_ent;
                        wr_ent.ambiguous = 1'b1;
                        ram_we           = 1'b1;
                        status_next      = ckm_pkg::ST_MADE_AMBIG;
                    end else if (!is_free || key_count_reg >= N_ENT) begin
                        status_next = ckm_pkg::ST_FULL;
                    end else begin
                        wr_ent.used        = 1'b1;
                        wr_ent.ambiguous   = 1'b0;
                        wr_ent.reverse     = gt_reg;
                        wr_ent.node_length = nlen_reg;
                        wr_ent.start       = start_reg;
                        wr_ent.node        = node_reg;
                        wr_ent.key         = canon_reg;
                        ram_we             = 1'b1;
                        key_count_next     = key_count_reg + CW'(1);
                        status_next        = ckm_pkg::ST_INSERTED;
                    end
                end else if (!hit) begin
                    status_next = ckm_pkg::ST_MISS;
                    state_next  = S_OUT;
                end else if (rd_ent.ambiguous) begin
                    status_next = ckm_pkg::ST_AMBIG;
                    state_next  = S_OUT;
                end else begin
                    ent_next    = rd_ent;
                    orient_next = rd_ent.reverse ^ gt_reg;
                    state_next  = S_POS;
                end
            end
            S_POS: begin
                if (orient_reg) begin
                    sum_next = $signed({4'b0, ent_reg.node_length})
                             - $signed({4'b0, ent_reg.start})
                             - $signed({31'b0, k_eff});
                end else begin
                    sum_next = $signed({4'b0, ent_reg.start});
                end
                state_next = S_OFF;
            end
            S_OFF: begin
                if (off > OFF_HI) begin
                    hit_off_next = OFF_HI[ckm_pkg::OFF_W-1:0];
                end else if (off < OFF_LO) begin
                    hit_off_next = OFF_LO[ckm_pkg::OFF_W-1:0];
                end else begin
                    hit_off_next = off[ckm_pkg::OFF_W-1:0];
                end
                hit_node_next   = ent_reg.node;
                hit_orient_next = orient_reg;
                status_next     = ckm_pkg::ST_HIT;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            key_count_reg   <= '0;
            kmer_length_reg <= ckm_pkg::K_RESET;
        end else begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            key_count_reg   <= key_count_next;
            kmer_length_reg <= kmer_length_next;
        end
        req_reg        <= req_next;
        code_reg       <= code_next;
        node_reg       <= node_next;
        nlen_reg       <= nlen_next;
        gt_reg         <= gt_next;
        canon_reg      <= canon_next;
        start_reg      <= start_next;
        slot_reg       <= slot_next;
        probe_cnt_reg  <= probe_cnt_next;
        ent_reg        <= ent_next;
        orient_reg     <= orient_next;
        sum_reg        <= sum_next;
        status_reg     <= status_next;
        out_canon_reg  <= out_canon_next;
        hit_node_reg   <= hit_node_next;
        hit_orient_reg <= hit_orient_next;
        hit_off_reg    <= hit_off_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= N_ENT)
        else $error("key count above table size");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_CHECK))
        else $error("table write outside clear or check");

    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_EVAL))
        else $error("accepted transaction not evaluated");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CHECK) |=> (key_count_reg == $past(key_count_reg)))
        else $error("key count changed outside check");

endmodule

// ===== rtl/ckm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ckm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ckm_window.sv =====
// Rolling forward and reverse-complement k-mer windows, run length and position.
// Depends on ckm_pkg.
module ckm_window (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ckm_pkg::win_ctl_t          ctl,
    input  logic [ckm_pkg::K_W-1:0]    k,
    output logic [ckm_pkg::KEY_W-1:0]  fwd,
    output logic [ckm_pkg::KEY_W-1:0]  rev,
    output logic [ckm_pkg::K_W-1:0]    run,
    output logic [ckm_pkg::POS_W-1:0]  pos
);

    logic [ckm_pkg::KEY_W-1:0] fwd_reg, fwd_next, rev_reg, rev_next, kmask, f0, r0;
    logic [ckm_pkg::K_W-1:0]   run_reg, run_next, run0;
    logic [ckm_pkg::POS_W-1:0] next_pos_reg, next_pos_next, pos_reg, pos_next;

    always_comb begin
        kmask = ~({ckm_pkg::KEY_W{1'b1}} << {k, 1'b0});
        f0    = ctl.first ? '0 : fwd_reg;
        r0    = ctl.first ? '0 : rev_reg;
        run0  = ctl.first ? '0 : run_reg;
        pos_next      = ctl.first ? '0 : next_pos_reg;
        next_pos_next = pos_next + ckm_pkg::POS_W'(1);
        if (ctl.code > ckm_pkg::CODE_W'(3)) begin
            fwd_next = '0;
            rev_next = '0;
            run_next = '0;
        end else begin
            fwd_next = {f0[ckm_pkg::KEY_W-3:0], ctl.code[1:0]} & kmask;
            rev_next = ((r0 >> 2)
                       | ({{(ckm_pkg::KEY_W-2){1'b0}}, ~ctl.code[1:0]}
                          << {k - ckm_pkg::K_W'(1), 1'b0})) & kmask;
            run_next = (&run0) ? run0 : run0 + ckm_pkg::K_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg      <= '0;
            rev_reg      <= '0;
            run_reg      <= '0;
            next_pos_reg <= '0;
            pos_reg      <= '0;
        end else if (ctl.en) begin
            fwd_reg      <= fwd_next;
            rev_reg      <= rev_next;
            run_reg      <= run_next;
            next_pos_reg <= next_pos_next;
            pos_reg      <= pos_next;
        end
    end

    assign fwd = fwd_reg;
    assign rev = rev_reg;
    assign run = run_reg;
    assign pos = pos_reg;

endmodule

// ===== rtl/ckm_hash.sv =====
// Shared half-width multiplier with accumulator forming the home-slot hash.
// Depends on ckm_pkg.
module ckm_hash (
    input  logic                       aclk,
    input  ckm_pkg::hash_ctl_t         ctl,
    input  logic [ckm_pkg::KEY_W-1:0]  key,
    output logic [ckm_pkg::IDX_W-1:0]  slot
);

    localparam int HW = ckm_pkg::HALF_W;
    localparam int AW = ckm_pkg::HASH_W;

    logic [HW-1:0]   op_a, op_b;
    logic [2*HW-1:0] prod;
    logic [AW-1:0]   addend, acc_reg, acc_next;

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        case (ctl.term)
            ckm_pkg::TERM_LL: begin
                op_a = key[HW-1:0];
                op_b = ckm_pkg::HASH_MULT[HW-1:0];
            end
            ckm_pkg::TERM_LH: begin
                op_a = key[HW-1:0];
                op_b = ckm_pkg::HASH_MULT[2*HW-1:HW];
            end
            ckm_pkg::TERM_HL: begin
                op_a = key[2*HW-1:HW];
                op_b = ckm_pkg::HASH_MULT[HW-1:0];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod = op_a * op_b;
        if (ctl.term == ckm_pkg::TERM_LL) begin
            addend = prod[AW-1:0];
        end else begin
            addend = {prod[AW-HW-1:0], {HW{1'b0}}};
        end
        if (ctl.term == ckm_pkg::TERM_NONE) begin
            acc_next = acc_reg;
        end else begin
            acc_next = (ctl.clear ? '0 : acc_reg) + addend;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign slot = acc_reg[AW-1 -: ckm_pkg::IDX_W];

endmodule

// ===== tb/canonical_kmer_seed_index_tb.sv =====
// Testbench for canonical_kmer_seed_index: directed and random base streams in index and query
// mode, each result checked against an in-bench seed table predictor.
// Depends on ckm_pkg and the RTL of canonical_kmer_seed_index.
`timescale 1ns / 1ps

module canonical_kmer_seed_index_tb;

    localparam int WATCHDOG_CYCLES = 60000;
    localparam logic REQ_QUERY = 1'b1;
    localparam logic [2:0] B_A = 3'd0, B_C = 3'd1, B_G = 3'd2, B_T = 3'd3;

    typedef struct packed {
        logic [ckm_pkg::STATUS_W-1:0] status;
        logic [ckm_pkg::KEY_W-1:0]    kmer;
        logic [ckm_pkg::POS_W-1:0]    node;
        logic                         orient;
        logic [ckm_pkg::OFF_W-1:0]    offset;
    } seed_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [ckm_pkg::K_W-1:0]       cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ckm_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [ckm_pkg::M_TDATA_W-1:0] m_tdata;

    canonical_kmer_seed_index u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // predictor state
    logic [ckm_pkg::K_W-1:0]   kmer_len;
    logic [63:0]               fwd_win;
    logic [63:0]               rev_win;
    int unsigned               run_len;
    logic [31:0]               base_pos;
    int unsigned               keys_stored;
    bit                        slot_used   [ckm_pkg::TABLE_ENTRIES];
    logic [ckm_pkg::KEY_W-1:0] slot_key    [ckm_pkg::TABLE_ENTRIES];
    logic [31:0]               slot_node   [ckm_pkg::TABLE_ENTRIES];
    logic [31:0]               slot_start  [ckm_pkg::TABLE_ENTRIES];
    logic [31:0]               slot_nlen   [ckm_pkg::TABLE_ENTRIES];
    bit                        slot_rev    [ckm_pkg::TABLE_ENTRIES];
    bit                        slot_ambig  [ckm_pkg::TABLE_ENTRIES];

    seed_result_t pending_results[$];
    bit           failed;
    bit           idle_on;
    int           m_stall = 0;
    int           quiet_cycles = 0;
    logic [1:0]   seq_lib[8][$];
    int           lib_next;

    function automatic int unsigned home_slot(logic [ckm_pkg::KEY_W-1:0] key);
        logic [63:0] h;
        h = {2'b00, key} * ckm_pkg::HASH_MULT;
        return 32'(h[32 +: ckm_pkg::IDX_W]);
    endfunction

    // returns slot holding key or first free slot; TABLE_ENTRIES when neither
    function automatic int unsigned find_slot(logic [ckm_pkg::KEY_W-1:0] key, output bit hit);
        int unsigned s;
        s = home_slot(key);
        hit = 1'b0;
        for (int n = 0; n < ckm_pkg::TABLE_ENTRIES; n++) begin
            if (!slot_used[s]) return s;
            if (slot_key[s] == key) begin
                hit = 1'b1;
                return s;
            end
            s = (s + 1 == ckm_pkg::TABLE_ENTRIES) ? 0 : s + 1;
        end
        return ckm_pkg::TABLE_ENTRIES;
    endfunction

    function automatic seed_result_t lookup_base(logic query, logic [2:0] code, logic first,
                                                 logic [31:0] node, logic [31:0] nlen);
        seed_result_t r;
        int unsigned  k;
        logic [63:0]  kmask;
        logic [31:0]  p;
        logic [31:0]  wstart;
        logic [63:0]  canon;
        bit           hit;
        int unsigned  s;
        bit           o;
        longint       pos;
        longint       off;
        r = '0;
        k = (kmer_len < 2) ? 2 : kmer_len;
        kmask = (64'd1 << (2 * k)) - 1;
        if (first) begin
            fwd_win = '0;
            rev_win = '0;
            run_len = 0;
            base_pos = '0;
        end
        p = base_pos;
        base_pos = base_pos + 1;
        if (code > B_T) begin
            fwd_win = '0;
            rev_win = '0;
            run_len = 0;
            return r;
        end
        fwd_win = ((fwd_win << 2) | code) & kmask;
        rev_win = ((rev_win >> 2) | (64'(3 - code) << (2 * (k - 1)))) & kmask;
        if (run_len < 31) run_len++;
        if (run_len < k) return r;
        canon = (fwd_win < rev_win) ? fwd_win : rev_win;
        wstart = p + 1 - k;
        s = find_slot(canon[ckm_pkg::KEY_W-1:0], hit);
        r.kmer = canon[ckm_pkg::KEY_W-1:0];
        if (query == ckm_pkg::REQ_INDEX) begin
            if (fwd_win == rev_win) begin
                r.status = ckm_pkg::ST_PALINDROME;
            end else if (hit) begin
                slot_ambig[s] = 1'b1;
                r.status = ckm_pkg::ST_MADE_AMBIG;
            end else if (keys_stored >= ckm_pkg::TABLE_ENTRIES ||
                         s >= ckm_pkg::TABLE_ENTRIES) begin
                r.status = ckm_pkg::ST_FULL;
            end else begin
                slot_used[s]  = 1'b1;
                slot_key[s]   = canon[ckm_pkg::KEY_W-1:0];
                slot_node[s]  = node;
                slot_start[s] = wstart;
                slot_nlen[s]  = nlen;
                slot_rev[s]   = (fwd_win != canon);
                slot_ambig[s] = 1'b0;
                keys_stored++;
                r.status = ckm_pkg::ST_INSERTED;
            end
        end else if (!hit || s >= ckm_pkg::TABLE_ENTRIES) begin
            r.status = ckm_pkg::ST_MISS;
        end else if (slot_ambig[s]) begin
            r.status = ckm_pkg::ST_AMBIG;
        end else begin
            o = slot_rev[s] ^ (fwd_win > rev_win);
            if (o)
                pos = longint'({32'd0, slot_nlen[s]}) - longint'({32'd0, slot_start[s]})
                      - longint'(k);
            else
                pos = longint'({32'd0, slot_start[s]});
            off = pos - longint'({32'd0, wstart});
            if (off > 64'sd8589934591) off = 64'sd8589934591;
            if (off < -64'sd8589934592) off = -64'sd8589934592;
            r.status = ckm_pkg::ST_HIT;
            r.node   = slot_node[s];
            r.orient = o;
            r.offset = off[ckm_pkg::OFF_W-1:0];
        end
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge after the transaction
    task automatic send_base(logic query, logic [2:0] code, logic first,
                             logic [31:0] node, logic [31:0] nlen);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        pending_results.insert(pending_results.size(),
                               lookup_base(query, code, first, node, nlen));
        s_tvalid = 1'b1;
        s_tuser  = query;
        s_tdata  = {4'd0, nlen, node, first, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_kmer_length(logic [ckm_pkg::K_W-1:0] k);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = k;
        kmer_len  = k;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic send_word(logic query, logic [2:0] b0, logic [2:0] b1,
                             logic [31:0] node, logic [31:0] nlen);
        send_base(query, b0, 1'b1, node, nlen);
        send_base(query, b1, 1'b0, node, nlen);
    endtask

    task automatic test_directed_short_k();
        set_kmer_length(5'd2);
        send_word(ckm_pkg::REQ_INDEX, B_A, B_T, 32'd1, 32'd10);     // palindrome
        send_word(ckm_pkg::REQ_INDEX, B_A, B_C, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ckm_pkg::REQ_INDEX, B_A, B_C, 32'd0, 32'd0);      // repeat
        send_word(REQ_QUERY, B_A, B_C, 32'd0, 32'd0);               // ambiguous
        send_word(ckm_pkg::REQ_INDEX, B_C, B_C, 32'h8000_0001, 32'd0);
        send_word(REQ_QUERY, B_G, B_G, 32'd0, 32'd0);               // reversed hit
        send_word(REQ_QUERY, B_C, B_C, 32'd0, 32'd0);
        send_word(REQ_QUERY, B_A, B_T, 32'd0, 32'd0);               // query palindrome
        send_base(REQ_QUERY, B_G, 1'b0, 32'd0, 32'd0);              // miss
        for (int c = 4; c < 8; c++) send_base(ckm_pkg::REQ_INDEX, 3'(c), 1'b0, 32'd5, 32'd5);
        send_base(ckm_pkg::REQ_INDEX, B_T, 1'b0, 32'd5, 32'd5);
        send_base(ckm_pkg::REQ_INDEX, B_G, 1'b0, 32'd5, 32'd5);
    endtask

    task automatic test_kmer_length_edges();
        set_kmer_length(5'd0);
        send_word(ckm_pkg::REQ_INDEX, B_G, B_A, 32'd9, 32'd3);
        set_kmer_length(5'd1);
        send_word(REQ_QUERY, B_G, B_A, 32'd0, 32'd0);
        set_kmer_length(5'd5);
        send_base(ckm_pkg::REQ_INDEX, B_C, 1'b1, 32'd11, 32'd40);
        send_base(ckm_pkg::REQ_INDEX, B_A, 1'b0, 32'd11, 32'd40);
        send_base(ckm_pkg::REQ_INDEX, B_G, 1'b0, 32'd11, 32'd40);
        set_kmer_length(5'd3);                                      // shrink mid-window
        send_base(ckm_pkg::REQ_INDEX, B_T, 1'b0, 32'd11, 32'd40);
        send_base(REQ_QUERY, B_C, 1'b0, 32'd0, 32'd0);
    endtask

    task automatic send_noise_base();
        send_base(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)), $urandom(), $urandom());
    endtask

    task automatic test_random_phase(logic [ckm_pkg::K_W-1:0] k, int n_items);
        int          sent;
        int          len;
        int          pick;
        int          from;
        logic [31:0] node;
        logic [31:0] nlen;
        logic [2:0]  b;
        bit          rc;
        set_kmer_length(k);
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len  = $urandom_range(k, k + 30);
                    node = $urandom();
                    nlen = ($urandom_range(0, 1) != 0) ? 32'(len) : $urandom();
                    seq_lib[lib_next].delete();
                    for (int i = 0; i < len; i++) begin
                        b = ($urandom_range(0, 39) == 0) ? 3'($urandom_range(4, 7))
                                                          : 3'($urandom_range(0, 3));
                        seq_lib[lib_next].insert(seq_lib[lib_next].size(), b[1:0]);
                        send_base(ckm_pkg::REQ_INDEX, b, i == 0, node, nlen);
                    end
                    lib_next = (lib_next + 1) % 8;
                    sent += len;
                end
                4, 5, 6, 7, 8: begin
                    pick = $urandom_range(0, 7);
                    if (seq_lib[pick].size() == 0) continue;
                    len  = $urandom_range(1, seq_lib[pick].size());
                    from = $urandom_range(0, seq_lib[pick].size() - len);
                    rc   = 1'($urandom_range(0, 1));
                    for (int i = 0; i < len; i++) begin
                        b = rc ? 3'(3 - seq_lib[pick][from + len - 1 - i])
                               : 3'(seq_lib[pick][from + i]);
                        if ($urandom_range(0, 49) == 0) b = 3'($urandom_range(0, 7));
                        send_base(REQ_QUERY, b, i == 0, $urandom(), $urandom());
                    end
                    sent += len;
                end
                default: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_noise_base();
                        sent++;
                    end
                end
            endcase
        end
    endtask

    always @(negedge aclk) begin
        if (m_stall > 0) begin
            m_tready <= 1'b0;
            m_stall  <= m_stall - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            m_stall  <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        seed_result_t want;
        seed_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[64:3], m_tdata[96:65], m_tdata[97], m_tdata[131:98]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, m_tdata);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (want.status !== got.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    failed = 1'b1;
                end
                if (want.kmer !== got.kmer) begin
                    $display("%0t: kmer exp %h got %h", $time, want.kmer, got.kmer);
                    failed = 1'b1;
                end
                if (want.node !== got.node) begin
                    $display("%0t: hit_node exp %h got %h", $time, want.node, got.node);
                    failed = 1'b1;
                end
                if (want.orient !== got.orient) begin
                    $display("%0t: hit_orient exp %0d got %0d", $time, want.orient, got.orient);
                    failed = 1'b1;
                end
                if (want.offset !== got.offset) begin
                    $display("%0t: hit_offset exp %h got %h", $time, want.offset, got.offset);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("canonical_kmer_seed_index_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        failed       = 1'b0;
        idle_on      = 1'b1;
        lib_next     = 0;
        kmer_len     = ckm_pkg::K_RESET;
        fwd_win      = '0;
        rev_win      = '0;
        run_len      = 0;
        base_pos     = '0;
        keys_stored  = 0;
        for (int i = 0; i < ckm_pkg::TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_short_k();
        test_kmer_length_edges();
        test_random_phase(5'd2, 150);
        test_random_phase(5'd3, 200);
        test_random_phase(5'd5, 250);
        test_random_phase(5'd8, 250);
        test_random_phase(5'($urandom_range(9, 30)), 250);
        test_random_phase(5'd31, 300);
        test_random_phase(5'd12, 250);
        idle_on = 1'b0;
        test_random_phase(5'd20, 200);

        drain();
        repeat (20) @(negedge aclk);
        if (!failed && pending_results.size() == 0) begin
            $display("canonical_kmer_seed_index_tb: PASS");
        end else begin
            $display("canonical_kmer_seed_index_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== canonical_kmer_seed_index.f =====
rtl/ckm_pkg.sv
rtl/ckm_ram.sv
rtl/ckm_window.sv
rtl/ckm_hash.sv
rtl/canonical_kmer_seed_index.sv
tb/canonical_kmer_seed_index_tb.sv
